/* rtl/mprq_pkg.sv */
package mprq_pkg;

	localparam logic CMD_ENQUEUE = 1'b0;
	localparam logic CMD_DEQUEUE = 1'b1;

	typedef logic [1:0] mprq_state_t;

endpackage

/* rtl/mprq_if.sv */
interface mprq_req_if #(
	parameter int PRIORITY_BITS = 8,
	parameter int HANDLE_BITS   = 8
);
	logic                     valid;
	logic                     ready;
	logic                     command;
	logic [HANDLE_BITS-1:0]   process_handle;
	logic [PRIORITY_BITS-1:0] process_priority;

	modport source (output valid, command, process_handle, process_priority, input ready);
	modport sink (input valid, command, process_handle, process_priority, output ready);
endinterface

interface mprq_rsp_if #(
	parameter int HANDLE_BITS = 8
);
	logic                   valid;
	logic                   ready;
	logic [HANDLE_BITS-1:0] out_handle;
	logic                   out_valid;
	logic                   dropped_full;
	logic                   now_empty;

	modport source (output valid, out_handle, out_valid, dropped_full, now_empty, input ready);
	modport sink (input valid, out_handle, out_valid, dropped_full, now_empty, output ready);
endinterface

/* rtl/mprq_mem.sv */
module mprq_mem #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 16,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

/* rtl/mprq_seq.sv */
module mprq_seq
	import mprq_pkg::*;
#(
	parameter int QUEUE_DEPTH   = 16,
	parameter int PRIORITY_BITS = 8,
	parameter int HANDLE_BITS   = 8,
	localparam int AW = $clog2(QUEUE_DEPTH),
	localparam int CW = $clog2(QUEUE_DEPTH + 1),
	localparam int DW = PRIORITY_BITS + HANDLE_BITS
) (
	input  logic          clk,
	input  logic          arst_n,
	mprq_req_if.sink      req,
	mprq_rsp_if.source    res,
	output logic          mem_we,
	output logic [AW-1:0] mem_waddr,
	output logic [DW-1:0] mem_wdata,
	output logic [AW-1:0] mem_raddr,
	input  logic [DW-1:0] mem_rdata
);

	localparam mprq_state_t ST_IDLE  = 2'd0;
	localparam mprq_state_t ST_SCAN  = 2'd1;
	localparam mprq_state_t ST_SHIFT = 2'd2;
	localparam mprq_state_t ST_FIN   = 2'd3;

	mprq_state_t              state_q;
	logic [CW-1:0]            count_q;
	logic [CW-1:0]            rd_q;
	logic                     vld_s1;
	logic [AW-1:0]            addr_s1;
	logic [AW-1:0]            best_idx_q;
	logic [PRIORITY_BITS-1:0] best_prio_q;
	logic [HANDLE_BITS-1:0]   best_hdl_q;
	logic [HANDLE_BITS-1:0]   res_hdl_q;
	logic                     res_ok_q;
	logic                     res_drop_q;
	logic                     res_empty_q;

	logic                     accept;
	logic                     full;
	logic [PRIORITY_BITS-1:0] prio_s1;
	logic [HANDLE_BITS-1:0]   hdl_s1;
	logic                     take;
	logic [AW-1:0]            cand_idx;
	logic [PRIORITY_BITS-1:0] cand_prio;
	logic [HANDLE_BITS-1:0]   cand_hdl;
	logic                     last_s1;
	logic                     scan_end;
	logic [CW-1:0]            cand_nxt;
	logic [CW-1:0]            shift_nxt;

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign full      = (count_q == CW'(QUEUE_DEPTH));

	assign prio_s1   = mem_rdata[DW-1:HANDLE_BITS];
	assign hdl_s1    = mem_rdata[HANDLE_BITS-1:0];
	assign take      = vld_s1 && ((addr_s1 == '0) || (prio_s1 > best_prio_q));
	assign cand_idx  = take ? addr_s1 : best_idx_q;
	assign cand_prio = take ? prio_s1 : best_prio_q;
	assign cand_hdl  = take ? hdl_s1 : best_hdl_q;
	assign last_s1   = ((CW'(addr_s1) + CW'(1)) == count_q);
	assign scan_end  = (state_q == ST_SCAN) && vld_s1 && last_s1;
	assign cand_nxt  = CW'(cand_idx) + CW'(1);
	assign shift_nxt = CW'(addr_s1) + CW'(1);

	// read address: scan walks the queue, shift reads two slots ahead of the write address
	always_comb begin
		unique case (state_q)
			ST_SCAN:  mem_raddr = scan_end ? cand_nxt[AW-1:0] : rd_q[AW-1:0];
			ST_SHIFT: mem_raddr = shift_nxt[AW-1:0];
			default:  mem_raddr = '0;
		endcase
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = count_q[AW-1:0];
		mem_wdata = {req.process_priority, req.process_handle};
		priority if (accept && req.command == CMD_ENQUEUE && !full) begin
			mem_we = 1'b1;
		end else if (state_q == ST_SHIFT && vld_s1) begin
			mem_we    = 1'b1;
			mem_waddr = addr_s1 - AW'(1);
			mem_wdata = mem_rdata;
		end
	end

	assign res.valid        = (state_q == ST_FIN);
	assign res.out_handle   = res_hdl_q;
	assign res.out_valid    = res_ok_q;
	assign res.dropped_full = res_drop_q;
	assign res.now_empty    = res_empty_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			rd_q    <= '0;
			vld_s1  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					vld_s1 <= 1'b0;
					if (accept) begin
						if (req.command == CMD_ENQUEUE) begin
							if (!full) begin
								count_q <= count_q + CW'(1);
							end
							state_q <= ST_FIN;
						end else if (count_q == '0) begin
							state_q <= ST_FIN;
						end else begin
							vld_s1  <= 1'b1;
							rd_q    <= CW'(1);
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (scan_end) begin
						vld_s1 <= (cand_nxt < count_q);
						if (cand_nxt < count_q) begin
							state_q <= ST_SHIFT;
						end else begin
							count_q <= count_q - CW'(1);
							state_q <= ST_FIN;
						end
					end else begin
						vld_s1 <= (rd_q < count_q);
						if (rd_q < count_q) begin
							rd_q <= rd_q + CW'(1);
						end
					end
				end
				ST_SHIFT: begin
					vld_s1 <= (shift_nxt < count_q);
					if (!(shift_nxt < count_q)) begin
						count_q <= count_q - CW'(1);
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					vld_s1 <= 1'b0;
					if (res.ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= mem_raddr;
		if (state_q == ST_SCAN && vld_s1) begin
			best_idx_q  <= cand_idx;
			best_prio_q <= cand_prio;
			best_hdl_q  <= cand_hdl;
		end
		if (accept) begin
			res_hdl_q <= '0;
			res_ok_q  <= 1'b0;
			if (req.command == CMD_ENQUEUE) begin
				res_drop_q  <= full;
				res_empty_q <= 1'b0;
			end else begin
				res_drop_q  <= 1'b0;
				res_empty_q <= 1'b1;
			end
		end else if (scan_end) begin
			res_hdl_q   <= cand_hdl;
			res_ok_q    <= 1'b1;
			res_drop_q  <= 1'b0;
			res_empty_q <= (count_q == CW'(1));
		end
	end

endmodule

/* rtl/max_priority_ready_queue.sv */
// Bounded ready queue of process handles with priorities, held in one
// synchronous memory in arrival order. An enqueue word appends at the tail
// (or is dropped with dropped_full when the queue is full). A dequeue word
// reads every stored entry through the single memory read port to find the
// highest priority (earliest entry wins a tie), then moves each later entry
// up one slot, one per cycle. One word is worked on at a time; a new word is
// taken while the previous result still waits in the output register. Every
// result reports now_empty.
module max_priority_ready_queue #(
	parameter int QUEUE_DEPTH   = 16,
	parameter int PRIORITY_BITS = 8,
	parameter int HANDLE_BITS   = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	mprq_req_if.sink   req,
	mprq_rsp_if.source rsp
);

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int DW = PRIORITY_BITS + HANDLE_BITS;

	logic                   mem_we;
	logic [AW-1:0]          mem_waddr;
	logic [DW-1:0]          mem_wdata;
	logic [AW-1:0]          mem_raddr;
	logic [DW-1:0]          mem_rdata;
	logic                   rsp_valid_q;
	logic [HANDLE_BITS-1:0] hdl_q;
	logic                   ok_q;
	logic                   drop_q;
	logic                   empty_q;
	logic                   load;

	mprq_rsp_if #(.HANDLE_BITS(HANDLE_BITS)) mid ();

	mprq_seq #(
		.QUEUE_DEPTH  (QUEUE_DEPTH),
		.PRIORITY_BITS(PRIORITY_BITS),
		.HANDLE_BITS  (HANDLE_BITS)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.res      (mid.source),
		.mem_we   (mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata)
	);

	mprq_mem #(
		.DEPTH(QUEUE_DEPTH),
		.WIDTH(DW)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// output register
	assign mid.ready = !rsp_valid_q || rsp.ready;
	assign load      = mid.valid && mid.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (mid.ready) begin
			rsp_valid_q <= mid.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			hdl_q   <= mid.out_handle;
			ok_q    <= mid.out_valid;
			drop_q  <= mid.dropped_full;
			empty_q <= mid.now_empty;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.out_handle   = hdl_q;
	assign rsp.out_valid    = ok_q;
	assign rsp.dropped_full = drop_q;
	assign rsp.now_empty    = empty_q;

endmodule

/* rtl/mprq_checker.sv */
module mprq_checker #(
	parameter int HANDLE_BITS = 8
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   req_valid,
	input logic                   req_ready,
	input logic                   rsp_valid,
	input logic                   rsp_ready,
	input logic [HANDLE_BITS-1:0] out_handle,
	input logic                   out_valid,
	input logic                   dropped_full,
	input logic                   now_empty
);

	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !rsp_valid)
		else $error("result word shown during reset");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_handle))
		else $error("stalled result word changed");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("new word taken while previous one in progress");

	a_no_handle: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !out_valid |-> out_handle == '0)
		else $error("handle shown without a dequeued process");

	a_drop_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && dropped_full |-> !out_valid && !now_empty)
		else $error("dropped word reported with a process or an empty queue");

endmodule

bind max_priority_ready_queue mprq_checker #(.HANDLE_BITS(HANDLE_BITS)) u_mprq_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.out_handle  (rsp.out_handle),
	.out_valid   (rsp.out_valid),
	.dropped_full(rsp.dropped_full),
	.now_empty   (rsp.now_empty)
);
